// ===== sv/xxh_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared constants, types and helpers for the streaming XXH64 hasher.
// ----------------------------------------------------------------------------
package xxh_pkg;

	localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
	localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

	// configuration register indexes
	localparam logic CFG_SEED    = 1'b0;
	localparam logic CFG_ADD_LEN = 1'b1;

	localparam logic [3:0] FULL_COUNT = 4'd8;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        last;
	} item_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		rotl = (x << r) | (x >> (64 - r));
	endfunction

endpackage

// ===== sv/xxh_if.sv =====
// ----------------------------------------------------------------------------
// xxh_if
// Valid/ready channels of the hasher: message words, hash results, register
// writes.
// ----------------------------------------------------------------------------
interface xxh_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_word;
	modport source (output valid, data_word, byte_count, last_word, input ready);
	modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xxh_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;
	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

interface xxh_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/xxh_mul.sv =====
// ----------------------------------------------------------------------------
// xxh_mul
// 64x64 -> low 64 bit multiplier, two stages of 32-bit partial products.
// ----------------------------------------------------------------------------
module xxh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic        vld_s1;
	logic [63:0] lolo_s1;
	logic [31:0] cross_s1;
	logic        vld_s2;
	logic [63:0] p_s2;
	logic [63:0] cross_a;
	logic [63:0] cross_b;

	assign cross_a = a[31:0] * b[63:32];
	assign cross_b = a[63:32] * b[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		lolo_s1  <= a[31:0] * b[31:0];
		cross_s1 <= cross_a[31:0] + cross_b[31:0];
		p_s2     <= lolo_s1 + {cross_s1, 32'd0};
	end

	assign done = vld_s2;
	assign p    = p_s2;
endmodule

// ===== sv/xxh_front.sv =====
// ----------------------------------------------------------------------------
// xxh_front
// Takes message beats, trims count and masks unused bytes, and queues them
// in a two-entry queue for the round engine.
// ----------------------------------------------------------------------------
module xxh_front (
	input  logic           clk,
	input  logic           arst_n,
	xxh_msg_if.sink        msg,
	output logic           q_valid,
	output xxh_pkg::item_t q_item,
	input  logic           q_pop
);
	xxh_pkg::item_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	logic [3:0]     cnt_eff;
	logic [63:0]    word_m;

	// non-last beats are always full; oversize counts clamp to eight
	always_comb begin
		if (!msg.last_word || msg.byte_count > xxh_pkg::FULL_COUNT)
			cnt_eff = xxh_pkg::FULL_COUNT;
		else
			cnt_eff = msg.byte_count;
		for (int i = 0; i < 8; i++) begin
			word_m[i*8 +: 8] = (4'(i) < cnt_eff) ? msg.data_word[i*8 +: 8] : 8'd0;
		end
	end

	assign msg.ready = (fill_q != 2'd2);
	assign push      = msg.valid && msg.ready;
	assign q_valid   = (fill_q != 2'd0);
	assign q_item    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{word: word_m, cnt: cnt_eff, last: msg.last_word};
		end
	end
endmodule

// ===== sv/xxh_back.sv =====
// ----------------------------------------------------------------------------
// xxh_back
// Round engine: lane rounds per stripe, convergence, tail folding and
// avalanche, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
module xxh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  xxh_pkg::item_t q_item,
	output logic           q_pop,
	input  logic [63:0]    seed,
	input  logic           add_length,
	xxh_hash_if.source     hash
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LANE_A = 4'd1;
	localparam logic [3:0] ST_LANE_B = 4'd2;
	localparam logic [3:0] ST_CONV = 4'd3;
	localparam logic [3:0] ST_MRG_A = 4'd4;
	localparam logic [3:0] ST_MRG_B = 4'd5;
	localparam logic [3:0] ST_MRG_C = 4'd6;
	localparam logic [3:0] ST_LEN = 4'd7;
	localparam logic [3:0] ST_TAIL = 4'd8;
	localparam logic [3:0] ST_W_A = 4'd9;
	localparam logic [3:0] ST_W_B = 4'd10;
	localparam logic [3:0] ST_B_A = 4'd11;
	localparam logic [3:0] ST_B_B = 4'd12;
	localparam logic [3:0] ST_AV_A = 4'd13;
	localparam logic [3:0] ST_AV_B = 4'd14;
	localparam logic [3:0] ST_OUT = 4'd15;

	logic [3:0]  state_q;
	logic [63:0] acc_q [4];
	logic [63:0] pend_q [3];
	logic [1:0]  pcnt_q;
	logic [63:0] total_q;
	logic        stripe_q;
	logic [63:0] h_q;
	logic [63:0] tmp_q;
	logic [63:0] word_q;
	logic        last_q;
	logic [63:0] rest_q;
	logic [3:0]  left_q;
	logic [1:0]  idx_q;
	logic        pmode_q;
	logic        iss_q;
	logic        ovalid_q;
	logic [63:0] hash_q;

	logic        mul_state;
	logic        mul_start;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic        mul_done;
	logic [63:0] mul_p;
	logic [63:0] pend_sel;
	logic [63:0] rot_sum;
	logic [63:0] fin_p;

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_comb begin
		case (idx_q)
			2'd1:    pend_sel = pend_q[1];
			2'd2:    pend_sel = pend_q[2];
			default: pend_sel = pend_q[0];
		endcase
	end

	assign rot_sum = xxh_pkg::rotl(acc_q[0], 1) + xxh_pkg::rotl(acc_q[1], 7) +
		xxh_pkg::rotl(acc_q[2], 12) + xxh_pkg::rotl(acc_q[3], 18);
	assign fin_p = mul_p ^ (mul_p >> 32);

	always_comb begin
		mul_state = 1'b1;
		mul_a     = h_q;
		mul_b     = xxh_pkg::PR1;
		case (state_q)
			ST_LANE_A: begin
				mul_a = (idx_q == 2'd3) ? word_q : pend_sel;
				mul_b = xxh_pkg::PR2;
			end
			ST_LANE_B: mul_a = xxh_pkg::rotl(acc_q[idx_q], 31);
			ST_MRG_A: begin
				mul_a = pmode_q ? pend_sel : acc_q[idx_q];
				mul_b = xxh_pkg::PR2;
			end
			ST_MRG_B: mul_a = xxh_pkg::rotl(tmp_q, 31);
			ST_MRG_C: mul_a = pmode_q ? xxh_pkg::rotl(h_q, 27) : h_q;
			ST_W_A:   mul_a = {32'd0, rest_q[31:0]};
			ST_W_B: begin
				mul_a = xxh_pkg::rotl(h_q, 23);
				mul_b = xxh_pkg::PR2;
			end
			ST_B_A: begin
				mul_a = {56'd0, rest_q[7:0]};
				mul_b = xxh_pkg::PR5;
			end
			ST_B_B:   mul_a = xxh_pkg::rotl(h_q, 11);
			ST_AV_A: begin
				mul_a = h_q ^ (h_q >> 33);
				mul_b = xxh_pkg::PR2;
			end
			ST_AV_B: begin
				mul_a = h_q ^ (h_q >> 29);
				mul_b = xxh_pkg::PR3;
			end
			default:  mul_state = 1'b0;
		endcase
	end

	assign mul_start = mul_state && !iss_q;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pcnt_q   <= 2'd0;
			total_q  <= 64'd0;
			stripe_q <= 1'b0;
			iss_q    <= 1'b0;
			ovalid_q <= 1'b0;
			idx_q    <= 2'd0;
			pmode_q  <= 1'b0;
		end else begin
			if (mul_start) iss_q <= 1'b1;
			if (mul_done) iss_q <= 1'b0;
			if (state_q == ST_OUT && (!ovalid_q || hash.ready)) ovalid_q <= 1'b1;
			else if (hash.valid && hash.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						total_q <= total_q + 64'(q_item.cnt);
						idx_q   <= 2'd0;
						if (q_item.cnt == xxh_pkg::FULL_COUNT && pcnt_q == 2'd3) begin
							if (!stripe_q) stripe_q <= 1'b1;
							state_q <= ST_LANE_A;
						end else begin
							if (q_item.cnt == xxh_pkg::FULL_COUNT) pcnt_q <= pcnt_q + 2'd1;
							if (q_item.last) state_q <= ST_CONV;
						end
					end
				end
				ST_LANE_A: if (mul_done) state_q <= ST_LANE_B;
				ST_LANE_B: begin
					if (mul_done) begin
						if (idx_q == 2'd3) begin
							pcnt_q  <= 2'd0;
							state_q <= last_q ? ST_CONV : ST_IDLE;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_LANE_A;
						end
					end
				end
				ST_CONV: begin
					idx_q   <= 2'd0;
					pmode_q <= 1'b0;
					state_q <= stripe_q ? ST_MRG_A : ST_LEN;
				end
				ST_MRG_A: if (mul_done) state_q <= ST_MRG_B;
				ST_MRG_B: if (mul_done) state_q <= ST_MRG_C;
				ST_MRG_C: begin
					if (mul_done) begin
						if (!pmode_q && idx_q == 2'd3) begin
							state_q <= ST_LEN;
						end else if (pmode_q && idx_q + 2'd1 == pcnt_q) begin
							state_q <= ST_TAIL;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_MRG_A;
						end
					end
				end
				ST_LEN: begin
					idx_q   <= 2'd0;
					pmode_q <= 1'b1;
					state_q <= (pcnt_q != 2'd0) ? ST_MRG_A : ST_TAIL;
				end
				ST_TAIL: begin
					if (left_q >= 4'd4) state_q <= ST_W_A;
					else if (left_q != 4'd0) state_q <= ST_B_A;
					else state_q <= ST_AV_A;
				end
				ST_W_A:  if (mul_done) state_q <= ST_W_B;
				ST_W_B:  if (mul_done) state_q <= ST_TAIL;
				ST_B_A:  if (mul_done) state_q <= ST_B_B;
				ST_B_B:  if (mul_done) state_q <= ST_TAIL;
				ST_AV_A: if (mul_done) state_q <= ST_AV_B;
				ST_AV_B: if (mul_done) state_q <= ST_OUT;
				ST_OUT: begin
					// hold while the previous hash is still waiting
					if (!ovalid_q || hash.ready) begin
						pcnt_q   <= 2'd0;
						total_q  <= 64'd0;
						stripe_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					word_q <= q_item.word;
					last_q <= q_item.last;
					rest_q <= q_item.word;
					left_q <= (q_item.cnt == xxh_pkg::FULL_COUNT) ? 4'd0 : q_item.cnt;
					if (q_item.cnt == xxh_pkg::FULL_COUNT && pcnt_q == 2'd3) begin
						if (!stripe_q) begin
							acc_q[0] <= seed + xxh_pkg::PR1 + xxh_pkg::PR2;
							acc_q[1] <= seed + xxh_pkg::PR2;
							acc_q[2] <= seed;
							acc_q[3] <= seed - xxh_pkg::PR1;
						end
					end else if (q_item.cnt == xxh_pkg::FULL_COUNT) begin
						pend_q[pcnt_q] <= q_item.word;
					end
				end
			end
			ST_LANE_A: if (mul_done) acc_q[idx_q] <= acc_q[idx_q] + mul_p;
			ST_LANE_B: if (mul_done) acc_q[idx_q] <= mul_p;
			ST_CONV:   h_q <= stripe_q ? rot_sum : seed + xxh_pkg::PR5;
			ST_MRG_A:  if (mul_done) tmp_q <= mul_p;
			ST_MRG_B:  if (mul_done) h_q <= h_q ^ mul_p;
			ST_MRG_C:  if (mul_done) h_q <= mul_p + xxh_pkg::PR4;
			ST_LEN:    if (add_length) h_q <= h_q + total_q;
			ST_W_A:    if (mul_done) h_q <= h_q ^ mul_p;
			ST_W_B: begin
				if (mul_done) begin
					h_q    <= mul_p + xxh_pkg::PR3;
					rest_q <= rest_q >> 32;
					left_q <= left_q - 4'd4;
				end
			end
			ST_B_A:    if (mul_done) h_q <= h_q ^ mul_p;
			ST_B_B: begin
				if (mul_done) begin
					h_q    <= mul_p;
					rest_q <= rest_q >> 8;
					left_q <= left_q - 4'd1;
				end
			end
			ST_AV_A:   if (mul_done) h_q <= mul_p;
			ST_AV_B:   if (mul_done) h_q <= fin_p;
			ST_OUT:    if (!ovalid_q || hash.ready) hash_q <= h_q;
			default: ;
		endcase
	end

	assign hash.valid      = ovalid_q;
	assign hash.hash_value = hash_q;

	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> iss_q)
		else $error("multiplier result without an issued operation");
	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == ST_OUT))
		else $error("hash raised outside the output step");
	a_pend_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRG_A && pmode_q) |-> (idx_q < pcnt_q))
		else $error("tail word index beyond pending count");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != ST_IDLE || !$past(q_item.last)))
		else $error("last beat did not start finalization");
endmodule

// ===== sv/xxhash64_stream.sv =====
// ----------------------------------------------------------------------------
// xxhash64_stream
// Streaming XXH64 hasher of a message given as little-endian 64-bit words.
// ----------------------------------------------------------------------------
// msg carries data_word, byte_count and last_word; a beat moves at valid and
// ready. byte_count is used on the last beat only (0..8), all others are full.
// hash carries one hash_value per message after its last beat.
// cfg writes seed (index 0) and add_length (index 1); it is always ready. It
// is to be written between messages; the block itself does not enforce this.
// A front queue of two beats decouples intake from the round engine, which
// runs every multiply through one two-stage 64-bit multiplier. A word that
// waits for a stripe is only buffered; the fourth word of a stripe runs
// eight multiplies. After the last beat the engine merges each lane when a
// stripe was seen, folds in each buffered word, then each 4-byte tail step
// and each tail byte, and ends with the avalanche.
// Reset clears the pending count, length and stripe flag, seed to 0 and
// add_length to 1. A stalled hash is held in the output register; the engine
// keeps accepting beats and waits only when a second hash is ready.
// ----------------------------------------------------------------------------
module xxhash64_stream (
	input  logic       clk,
	input  logic       arst_n,
	xxh_msg_if.sink    msg,
	xxh_cfg_if.sink    cfg,
	xxh_hash_if.source hash
);
	logic [63:0]    seed_q;
	logic           add_len_q;
	logic           q_valid;
	logic           q_pop;
	xxh_pkg::item_t q_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= 64'd0;
			add_len_q <= 1'b1;
		end else if (cfg.valid) begin
			if (cfg.index == xxh_pkg::CFG_SEED) seed_q <= cfg.data;
			else add_len_q <= cfg.data[0];
		end
	end

	xxh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	xxh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.seed       (seed_q),
		.add_length (add_len_q),
		.hash       (hash)
	);
endmodule
